// ===== rtl/core/cache_set_access_policy_assert.svh =====
// Assertion macros shared by the cache set access policy RTL.
// Each macro samples on clk_i; the guarded form is held off while rst_ni is low.
`ifndef CACHE_SET_ACCESS_POLICY_ASSERT_SVH
`define CACHE_SET_ACCESS_POLICY_ASSERT_SVH

// Check a property outside reset.
`define CSAP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property at every edge, reset included.
`define CSAP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/csap_pkg.sv =====
// ----------------------------------------------------------------------------
// csap_pkg
// Shared types and constants of the cache set access policy block.
// ----------------------------------------------------------------------------
`default_nettype none

package csap_pkg;

  // Set geometry
  localparam int WAYS     = 8;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNT_W    = $clog2(WAYS + 1);
  localparam int TAG_BITS = 32;
  localparam int TIME_W   = 32;

  // Cost model
  localparam int CYC_W      = 18;
  localparam int WORDS_W    = 11;
  localparam int MAX_WORDS  = 1024;
  localparam int MEM_CYCLES = 100;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int LIMIT_W    = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WRITE_ALLOCATE  = 3'd0,
    CFG_WRITE_THROUGH   = 3'd1,
    CFG_REPLACE_FIFO    = 3'd2,
    CFG_WAYS_IN_USE     = 3'd3,
    CFG_WORDS_PER_BLOCK = 3'd4
  } cfg_reg_e;

  // Access kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_STORE = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [TAG_BITS-1:0] tag;
  } in_item_t;

  typedef struct packed {
    logic             hit;
    logic [CYC_W-1:0] cycles_added;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_COMMIT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic lookup;
    logic scan_init;
    logic scan_step;
    logic commit;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_scan;
    logic scan_last;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/csap_ctrl.sv =====
// ----------------------------------------------------------------------------
// csap_ctrl
// Sequencer for one access: capture, lookup, optional victim scan, commit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "cache_set_access_policy_assert.svh"

module csap_ctrl (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  input  csap_pkg::dp_status_t   status_i,
  output csap_pkg::dp_cmd_t      cmd_o
);
  import csap_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   commit_ok;

  // Commit only when the output register is free or being drained.
  assign commit_ok = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        if (status_i.need_scan) begin
          cmd_o.scan_init = 1'b1;
          state_d         = ST_SCAN;
        end else begin
          state_d = ST_COMMIT;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (commit_ok) begin
          cmd_o.commit = 1'b1;
          in_stall_o   = 1'b0;
          if (in_valid_i) begin
            cmd_o.capture = 1'b1;
            state_d       = ST_LOOKUP;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  `CSAP_ASSERT(a_accept_state,
    (in_valid_i && !in_stall_o) |-> (state_q == ST_IDLE || state_q == ST_COMMIT),
    "csap_ctrl: beat accepted while an access is in flight")
  `CSAP_ASSERT(a_commit_slot,
    cmd_o.commit |-> (!out_valid_q || !out_stall_i),
    "csap_ctrl: commit would overwrite a waiting result")
  `CSAP_ASSERT(a_scan_exit,
    (state_q == ST_SCAN && status_i.scan_last) |=> (state_q == ST_COMMIT),
    "csap_ctrl: victim scan did not end in commit")

endmodule

`default_nettype wire

// ===== rtl/core/csap_dp.sv =====
// ----------------------------------------------------------------------------
// csap_dp
// Per-way state, tag compare, victim scan, cost calculation and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "cache_set_access_policy_assert.svh"

module csap_dp (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  csap_pkg::in_item_t                   in_data_i,
  output csap_pkg::out_item_t                  out_data_o,
  input  wire                                  cfg_we_i,
  input  wire   [csap_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire   [csap_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  csap_pkg::dp_cmd_t                    cmd_i,
  output csap_pkg::dp_status_t                 status_o
);
  import csap_pkg::*;

  // Configuration
  logic               wa_q, wt_q, fifo_q;
  logic [LIMIT_W-1:0] ways_q;
  logic [WORDS_W-1:0] words_q;

  // Per-way state
  logic [WAYS-1:0]     valid_q, valid_d;
  logic [WAYS-1:0]     dirty_q, dirty_d;
  logic [TAG_BITS-1:0] tag_q   [WAYS];
  logic [TIME_W-1:0]   ltime_q [WAYS];
  logic [TIME_W-1:0]   atime_q [WAYS];
  logic [TIME_W-1:0]   tc_q, tc_d;

  // Current access
  logic                kind_q;
  logic [TAG_BITS-1:0] acc_tag_q;
  logic                hit_q, alloc_q, evict_q;
  logic [WAY_W-1:0]    hit_way_q, free_way_q;

  // Victim scan
  logic [WAY_W-1:0]  scan_idx_q;
  logic              best_valid_q;
  logic [WAY_W-1:0]  best_way_q;
  logic [TIME_W-1:0] best_time_q;

  out_item_t out_q;

  // Lookup logic
  logic [WAYS-1:0]    hit_vec;
  logic               hit_c, alloc_c, evict_c, is_store;
  logic [WAY_W-1:0]   hit_way_c, free_way_c;
  logic               free_any;
  logic [CNT_W-1:0]   used_c, limit_c;
  logic [TIME_W-1:0]  scan_time;
  logic               scan_better;

  // Commit logic
  logic [WORDS_W-1:0] words_eff;
  logic [CYC_W-1:0]   mem_words, cycles_c;
  logic [WAY_W-1:0]   slot;
  logic               st_wb;

  assign is_store = (kind_q == KIND_STORE);

  always_comb begin
    hit_way_c  = '0;
    free_way_c = '0;
    free_any   = 1'b0;
    for (int i = 0; i < WAYS; i++) begin
      hit_vec[i] = valid_q[i] && (tag_q[i] == acc_tag_q);
    end
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (hit_vec[i]) hit_way_c = WAY_W'(i);
      if (!valid_q[i]) begin
        free_way_c = WAY_W'(i);
        free_any   = 1'b1;
      end
    end
  end

  assign hit_c  = |hit_vec;
  assign used_c = CNT_W'($countones(valid_q));

  always_comb begin
    if (ways_q == '0) begin
      limit_c = CNT_W'(1);
    end else if (32'(ways_q) > WAYS) begin
      limit_c = CNT_W'(WAYS);
    end else begin
      limit_c = CNT_W'(ways_q);
    end
  end

  assign alloc_c = !hit_c && (!is_store || wa_q);
  assign evict_c = (used_c >= limit_c) || !free_any;

  assign status_o.need_scan = alloc_c && evict_c;
  assign status_o.scan_last = (scan_idx_q == WAY_W'(WAYS - 1));

  // Victim compare: strict less keeps the lowest way on ties.
  assign scan_time   = fifo_q ? ltime_q[scan_idx_q] : atime_q[scan_idx_q];
  assign scan_better = valid_q[scan_idx_q] && (!best_valid_q || (scan_time < best_time_q));

  // Cost
  always_comb begin
    if (words_q == '0) begin
      words_eff = WORDS_W'(1);
    end else if (32'(words_q) > MAX_WORDS) begin
      words_eff = WORDS_W'(MAX_WORDS);
    end else begin
      words_eff = words_q;
    end
  end

  assign mem_words = CYC_W'(words_eff) * CYC_W'(MEM_CYCLES);
  assign st_wb     = is_store && !wt_q;
  assign slot      = evict_q ? best_way_q : free_way_q;

  always_comb begin
    cycles_c = '0;
    if (hit_q) begin
      cycles_c = (is_store && wt_q) ? CYC_W'(MEM_CYCLES + 1) : CYC_W'(1);
    end else begin
      if (is_store && wt_q) cycles_c = CYC_W'(MEM_CYCLES);
      if (alloc_q) begin
        cycles_c = cycles_c + mem_words + CYC_W'(1);
        if (evict_q && !wt_q && dirty_q[best_way_q]) begin
          cycles_c = cycles_c + mem_words;
        end
      end
    end
  end

  // Next state of control bits and time counter
  always_comb begin
    valid_d = valid_q;
    dirty_d = dirty_q;
    tc_d    = tc_q;
    if (cmd_i.commit) begin
      if (hit_q) begin
        if (st_wb) dirty_d[hit_way_q] = 1'b1;
        tc_d = tc_q + TIME_W'(2);
      end else begin
        if (alloc_q) begin
          valid_d[slot] = 1'b1;
          dirty_d[slot] = st_wb;
        end
        tc_d = tc_q + TIME_W'(1);
      end
    end
  end

  // Config and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wa_q         <= 1'b1;
      wt_q         <= 1'b0;
      fifo_q       <= 1'b0;
      ways_q       <= LIMIT_W'(8);
      words_q      <= WORDS_W'(4);
      valid_q      <= '0;
      dirty_q      <= '0;
      tc_q         <= '0;
      scan_idx_q   <= '0;
      best_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WRITE_ALLOCATE:  wa_q    <= cfg_wdata_i[0];
          CFG_WRITE_THROUGH:   wt_q    <= cfg_wdata_i[0];
          CFG_REPLACE_FIFO:    fifo_q  <= cfg_wdata_i[0];
          CFG_WAYS_IN_USE:     ways_q  <= cfg_wdata_i[LIMIT_W-1:0];
          CFG_WORDS_PER_BLOCK: words_q <= cfg_wdata_i[WORDS_W-1:0];
          default: ;
        endcase
      end
      valid_q <= valid_d;
      dirty_q <= dirty_d;
      tc_q    <= tc_d;
      if (cmd_i.scan_init) begin
        scan_idx_q   <= '0;
        best_valid_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        scan_idx_q <= scan_idx_q + 1'b1;
        if (scan_better) best_valid_q <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q    <= in_data_i.kind;
      acc_tag_q <= in_data_i.tag;
    end
    if (cmd_i.lookup) begin
      hit_q      <= hit_c;
      hit_way_q  <= hit_way_c;
      alloc_q    <= alloc_c;
      evict_q    <= evict_c;
      free_way_q <= free_way_c;
    end
    if (cmd_i.scan_step && scan_better) begin
      best_way_q  <= scan_idx_q;
      best_time_q <= scan_time;
    end
    if (cmd_i.commit) begin
      out_q.hit          <= hit_q;
      out_q.cycles_added <= cycles_c;
      if (hit_q) begin
        atime_q[hit_way_q] <= tc_q + TIME_W'(1);
      end else if (alloc_q) begin
        tag_q[slot]   <= acc_tag_q;
        ltime_q[slot] <= tc_q + TIME_W'(1);
        atime_q[slot] <= tc_q + TIME_W'(1);
      end
    end
  end

  assign out_data_o = out_q;

  `CSAP_ASSERT(a_single_hit,
    $onehot0(hit_vec),
    "csap_dp: tag held in more than one valid way")
  `CSAP_ASSERT(a_time_step,
    cmd_i.commit |=> (tc_q == $past(tc_q) + 32'd1) || (tc_q == $past(tc_q) + 32'd2),
    "csap_dp: time counter moved by other than one or two")
  `CSAP_ASSERT(a_time_hold,
    !cmd_i.commit |=> $stable(tc_q),
    "csap_dp: time counter moved outside commit")

endmodule

`default_nettype wire

// ===== rtl/core/cache_set_access_policy.sv =====
// ----------------------------------------------------------------------------
// cache_set_access_policy
// One set of a set-associative cache with LRU or FIFO replacement and cost report.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one access per
//   beat: kind (load or store) and tag. Output channel (out_valid_o /
//   out_stall_i / out_data_o) returns one beat per access: hit and the cycle
//   cost, including fill and dirty-victim writeback.
//   Order: an access that needs no eviction is captured, looked up, then
//   committed; a fill that must evict runs a victim scan between lookup and
//   commit, as the victim search walks the ways one at a time.
//   A new access is not taken while one is in flight; the next beat is taken
//   in the commit cycle of the previous one.
//   The result sits in an output register; while the receiver stalls, the
//   next access still runs its lookup and scan, then holds in commit until
//   the waiting beat is taken.
//   Configuration: cfg_we_i writes register cfg_idx_i (0 write_allocate,
//   1 write_through, 2 replace_fifo, 3 ways_in_use, 4 words_per_block);
//   write only while idle. Other indexes are dropped.
//   Reset: all ways invalid and clean, time counter zero, registers at their
//   defaults (allocate on, write-back, LRU, 8 ways, 4 words).
// ----------------------------------------------------------------------------
`default_nettype none

module cache_set_access_policy (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  csap_pkg::in_item_t                   in_data_i,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output csap_pkg::out_item_t                  out_data_o,
  input  wire                                  cfg_we_i,
  input  wire   [csap_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire   [csap_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import csap_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequence each access: capture, lookup, scan when evicting, commit.
  csap_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Hold the set state, compare tags, pick the victim and price the access.
  csap_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

`default_nettype wire

// ===== tb/cache_set_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cache_set_checker
// Watches both channels and the register port of one cache set. It keeps its
// own copy of the set's ways, time counter and settings. It predicts hit and
// cycle cost for every access beat taken, and compares each result beat taken
// with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module cache_set_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  csap_pkg::in_item_t                 in_data_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  csap_pkg::out_item_t                out_data_i,
  input  logic                               cfg_we_i,
  input  logic [csap_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [csap_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output int                                 outstanding_o,
  output int                                 errors_o,
  output int                                 results_o,
  output int                                 hits_o,
  output int                                 writebacks_o
);
  import csap_pkg::*;

  // Keep the log short when the block is badly broken.
  localparam int MAX_REPORTS = 50;

  logic                way_valid  [WAYS];
  logic [TAG_BITS-1:0] way_tag    [WAYS];
  logic                way_dirty  [WAYS];
  logic [TIME_W-1:0]   way_loaded [WAYS];
  logic [TIME_W-1:0]   way_used   [WAYS];
  logic [TIME_W-1:0]   access_clock;

  logic                alloc_on;
  logic                thru_on;
  logic                fifo_on;
  logic [LIMIT_W-1:0]  limit_reg;
  logic [WORDS_W-1:0]  words_reg;

  out_item_t           awaited_results [$];
  out_item_t           want;

  function automatic int unsigned block_words();
    if (words_reg == 0) return 1;
    if (words_reg > MAX_WORDS) return MAX_WORDS;
    return words_reg;
  endfunction

  function automatic int unsigned way_limit();
    if (limit_reg == 0) return 1;
    if (limit_reg > WAYS) return WAYS;
    return limit_reg;
  endfunction

  // Place a block; return the cost of writing back a dirty victim.
  function automatic int unsigned install_block(logic [TAG_BITS-1:0] tag, logic dirty);
    int unsigned       used;
    int                slot;
    int                victim;
    int unsigned       spill;
    logic [TIME_W-1:0] t_i;
    logic [TIME_W-1:0] t_v;
    used  = 0;
    slot  = -1;
    spill = 0;
    for (int i = 0; i < WAYS; i++) begin
      if (way_valid[i]) used++;
      else if (slot < 0) slot = i;
    end
    if (used >= way_limit() || slot < 0) begin
      // Evict among all valid ways, also those beyond the limit.
      victim = -1;
      for (int i = 0; i < WAYS; i++) begin
        if (way_valid[i]) begin
          if (victim < 0) begin
            victim = i;
          end else begin
            t_i = fifo_on ? way_loaded[i] : way_used[i];
            t_v = fifo_on ? way_loaded[victim] : way_used[victim];
            if (t_i < t_v) victim = i;
          end
        end
      end
      if (victim < 0) victim = 0;
      if (!thru_on && way_valid[victim] && way_dirty[victim]) begin
        spill = block_words() * MEM_CYCLES;
        writebacks_o++;
      end
      slot = victim;
    end
    way_valid[slot]  = 1'b1;
    way_tag[slot]    = tag;
    way_dirty[slot]  = dirty;
    way_loaded[slot] = access_clock;
    way_used[slot]   = access_clock;
    return spill;
  endfunction

  function automatic out_item_t predict_access(in_item_t acc);
    out_item_t   res;
    logic        found;
    int unsigned cost;
    int unsigned fill;
    found = 1'b0;
    cost  = 0;
    fill  = block_words() * MEM_CYCLES + 1;
    access_clock = access_clock + 1'b1;
    for (int i = 0; i < WAYS; i++) begin
      if (!found && way_valid[i] && way_tag[i] == acc.tag) begin
        found = 1'b1;
        if (acc.kind == KIND_STORE && thru_on) begin
          cost = MEM_CYCLES + 1;
        end else begin
          if (acc.kind == KIND_STORE) way_dirty[i] = 1'b1;
          cost = 1;
        end
        way_used[i]  = access_clock;
        access_clock = access_clock + 1'b1;
      end
    end
    if (!found) begin
      if (acc.kind == KIND_LOAD) begin
        cost = install_block(acc.tag, 1'b0) + fill;
      end else begin
        if (thru_on) cost = MEM_CYCLES;
        if (alloc_on) cost = cost + install_block(acc.tag, !thru_on) + fill;
      end
    end
    res.hit          = found;
    res.cycles_added = cost[CYC_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    errors_o++;
    if (errors_o <= MAX_REPORTS) $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WAYS; i++) begin
        way_valid[i]  = 1'b0;
        way_tag[i]    = '0;
        way_dirty[i]  = 1'b0;
        way_loaded[i] = '0;
        way_used[i]   = '0;
      end
      access_clock = '0;
      alloc_on     = 1'b1;
      thru_on      = 1'b0;
      fifo_on      = 1'b0;
      limit_reg    = LIMIT_W'(WAYS);
      words_reg    = WORDS_W'(4);
      awaited_results.delete();
      errors_o      = 0;
      results_o     = 0;
      hits_o        = 0;
      writebacks_o  = 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_WRITE_ALLOCATE:  alloc_on  = cfg_wdata_i[0];
          CFG_WRITE_THROUGH:   thru_on   = cfg_wdata_i[0];
          CFG_REPLACE_FIFO:    fifo_on   = cfg_wdata_i[0];
          CFG_WAYS_IN_USE:     limit_reg = cfg_wdata_i[LIMIT_W-1:0];
          CFG_WORDS_PER_BLOCK: words_reg = cfg_wdata_i[WORDS_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        results_o++;
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result beat with no access waiting (hit %b, cycles %0d)",
                                    out_data_i.hit, out_data_i.cycles_added));
        end else begin
          want = awaited_results.pop_front();
          if (want.hit) hits_o++;
          if (out_data_i.hit !== want.hit)
            report_mismatch($sformatf("result %0d: hit %b, expected %b",
                                      results_o, out_data_i.hit, want.hit));
          if (out_data_i.cycles_added !== want.cycles_added)
            report_mismatch($sformatf("result %0d: cycles_added %0d, expected %0d",
                                      results_o, out_data_i.cycles_added,
                                      want.cycles_added));
        end
      end
      // Queue the prediction behind every one still waiting.
      if (in_valid_i && !in_stall_i)
        awaited_results.insert(awaited_results.size(), predict_access(in_data_i));
      outstanding_o <= awaited_results.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the cache set access policy block.
// A short directed run fills the set, evicts clean and dirty victims and walks
// the out-of-range register values. Random phases follow under eight register
// settings, with back-to-back traffic, sender gaps, receiver stalls and both.
// The checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb;
  import csap_pkg::*;

  // One full register setting, written as a batch while the set is idle.
  typedef struct packed {
    logic               alloc;
    logic               thru;
    logic               fifo;
    logic [LIMIT_W-1:0] ways;
    logic [WORDS_W-1:0] words;
  } cache_setting_t;

  // Index that maps to no register; the block must drop such writes.
  localparam logic [CFG_IDX_W-1:0] UNUSED_IDX = 3'd7;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_BEATS   = 200;
  // An unstalled access at most runs a lookup, a victim scan over all eight ways and a commit.
  localparam int DRAIN_CYCLES  = 16;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_data_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  int idle_pct       = 0;
  int stall_pct      = 0;
  int settings_used  = 1;
  int outstanding;
  int errors;
  int results;
  int hits;
  int writebacks;

  always #2 clk_i = ~clk_i;

  cache_set_access_policy dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  cache_set_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .in_data_i     (in_data_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_i    (out_data_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .outstanding_o (outstanding),
    .errors_o      (errors),
    .results_o     (results),
    .hits_o        (hits),
    .writebacks_o  (writebacks)
  );

  // Receiver side: stall at random per the current phase, never in reset.
  always @(posedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(99) < stall_pct);
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("cache_set_access_policy test failed");
    $finish;
  end

  // Present one access beat and hold it until the block takes it. Valid stays
  // high on return so back-to-back beats need no extra assignment.
  task automatic send_access(logic kind, logic [TAG_BITS-1:0] tag);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= {kind, tag};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Drop valid and hold until every predicted result beat has come back.
  // Wait for a clock edge first: the checker's count is registered and lags the accepting edge.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // Leave the write enable high; the caller drops it after the batch.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  task automatic apply_setting(cache_setting_t s);
    drain_results();
    write_reg(CFG_WRITE_ALLOCATE,  CFG_DATA_W'(s.alloc));
    write_reg(CFG_WRITE_THROUGH,   CFG_DATA_W'(s.thru));
    write_reg(CFG_REPLACE_FIFO,    CFG_DATA_W'(s.fifo));
    write_reg(CFG_WAYS_IN_USE,     CFG_DATA_W'(s.ways));
    write_reg(CFG_WORDS_PER_BLOCK, s.words);
    // Random junk to a dead index must leave every register alone.
    write_reg(UNUSED_IDX, CFG_DATA_W'($urandom));
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Settings of the random phases: both values of every flag, both extremes
  // of the block size, which lie out of range, a way limit above the way count, and several mid values.
  function automatic cache_setting_t phase_setting(int p);
    case (p)
      0:       return {1'b1, 1'b0, 1'b0, 4'd8,  11'd4};
      1:       return {1'b1, 1'b0, 1'b1, 4'd4,  11'd1};
      2:       return {1'b0, 1'b0, 1'b0, 4'd3,  11'd16};
      3:       return {1'b1, 1'b1, 1'b0, 4'd1,  11'd1024};
      4:       return {1'b0, 1'b1, 1'b1, 4'd8,  11'd2047};
      5:       return {1'b1, 1'b0, 1'b1, 4'd15, 11'd0};
      6:       return {1'b1, 1'b0, 1'b0, 4'd2,  11'd7};
      default: return {1'b0, 1'b0, 1'b1, 4'd6,  11'd100};
    endcase
  endfunction

  // Mostly tags from a pool a bit larger than the usable ways, so hits,
  // fills and evictions all come often; the rest are repeats and wild tags.
  task automatic run_random_phase(cache_setting_t s);
    logic [TAG_BITS-1:0] base;
    logic [TAG_BITS-1:0] recent;
    logic [TAG_BITS-1:0] tag;
    logic                kind;
    int                  span;
    int                  pick;
    base   = $urandom;
    recent = base;
    span   = (s.ways == 0) ? 1 : ((s.ways > WAYS) ? WAYS : int'(s.ways));
    span   = span + 2;
    repeat (PHASE_BEATS) begin
      // Now and then hold the sender until the set has fully drained.
      if ($urandom_range(99) == 0) drain_results();
      pick = $urandom_range(99);
      if (pick < 10)      tag = $urandom;
      else if (pick < 20) tag = recent;
      else                tag = {base[TAG_BITS-1:4], 4'($urandom_range(span - 1))};
      kind = 1'($urandom_range(1));
      send_access(kind, tag);
      recent = tag;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults: allocate, write-back, LRU, eight ways, four words.
    // Miss, hit, dirty fill by a store, then a dirty store hit.
    send_access(KIND_LOAD,  32'h0000_0000);
    send_access(KIND_LOAD,  32'h0000_0000);
    send_access(KIND_STORE, 32'hFFFF_FFFF);
    send_access(KIND_STORE, 32'h0000_0000);
    // Fill the free ways lowest first until the set is full.
    for (int t = 1; t <= 6; t++) send_access(KIND_LOAD, TAG_BITS'(t));
    // Full set: evict the two dirty ways in LRU order, the second with a dirty fill.
    send_access(KIND_LOAD,  32'hAAAA_AAAA);
    send_access(KIND_STORE, 32'h5555_5555);

    // Write-through without allocation, way limit zero, block size zero:
    // each store miss costs one memory trip, and a load
    // with eight valid ways under a limit of one evicts exactly one.
    apply_setting({1'b0, 1'b1, 1'b0, 4'd0, 11'd0});
    send_access(KIND_STORE, 32'h0000_0009);
    send_access(KIND_STORE, 32'h0000_0000);
    send_access(KIND_LOAD,  32'h0000_000A);

    // Write-back without allocation, limit above the way count, block size
    // above the maximum, FIFO: a free store miss, then the oldest-loaded way,
    // which is clean, is refilled at the largest block size, then a hit on the new block.
    apply_setting({1'b0, 1'b0, 1'b1, 4'd15, 11'd2047});
    send_access(KIND_STORE, 32'h0000_000B);
    send_access(KIND_LOAD,  32'h0000_000C);
    send_access(KIND_LOAD,  32'h0000_000C);

    // Limit lowered well below occupancy: a store miss allocates dirty.
    apply_setting({1'b1, 1'b0, 1'b0, 4'd2, 11'd1});
    send_access(KIND_STORE, 32'h8000_0000);
    send_access(KIND_STORE, 32'h8000_0000);

    // Random phases; the idle mode cycles through none, sender gaps,
    // receiver stalls and both.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      apply_setting(phase_setting(p));
      case (p % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 69; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 69; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase
      run_random_phase(phase_setting(p));
    end

    // Wait out the last results, then a little longer for stray beats.
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d accesses under %0d register settings: %0d hits, %0d dirty writebacks.",
             results, settings_used, hits, writebacks);
    $display("Traffic ran back to back, with sender gaps, with receiver stalls and with both.");
    if (errors == 0) begin
      $display("cache_set_access_policy test passed");
    end else begin
      $display("cache_set_access_policy test failed");
    end
    $finish;
  end

endmodule
